[src/tlis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-axis line step interpolator package
// Shared command codes, field widths and the per-axis control struct.
// ----------------------------------------------------------------------------
package tlis_pkg;

    localparam int FIELD_W = 24;
    localparam int MAG_W   = 25;
    localparam int ERR_W   = 26;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef enum logic [1:0] {
        CMD_REL  = 2'd0,
        CMD_ABS  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef struct packed {
        logic load;      // move command taken this cycle
        logic absolute;  // move target is an absolute position
        logic tick;      // one DDA iteration this cycle
    } axis_ctl_t;

endpackage

[src/tlis_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single axis DDA datapath
// Holds position, magnitude, error and direction of one axis, derives the
// move magnitude on a command and takes one Bresenham step on a tick.
// ----------------------------------------------------------------------------
module tlis_axis #(
    parameter int POS_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tlis_pkg::axis_ctl_t                 ctl,
    input  logic signed [tlis_pkg::FIELD_W-1:0] move,
    input  logic [tlis_pkg::MAG_W-1:0]          major,
    output logic                                step,
    output logic                                dir_next,
    output logic signed [POS_BITS-1:0]          pos_next,
    output logic [tlis_pkg::MAG_W-1:0]          mag_load
);
    import tlis_pkg::*;

    localparam int DW = ((POS_BITS > FIELD_W) ? POS_BITS : FIELD_W) + 1;

    logic signed [POS_BITS-1:0] pos_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [ERR_W-1:0]           err_reg;
    logic                       dir_reg;

    logic signed [DW-1:0] delta;
    logic [DW-1:0]        abs_val;
    logic                 dir_load;
    logic [ERR_W-1:0]     err_sum;
    logic [ERR_W-1:0]     err_next;
    logic signed [POS_BITS-1:0] pos_step;

    always_comb
    begin
        // The difference is one bit wider than either operand, so it is exact.
        if (ctl.absolute)
        begin
            delta = DW'(move) - DW'(pos_reg);
        end
        else
        begin
            delta = DW'(move);
        end
        dir_load = ~delta[DW-1];
        abs_val  = delta[DW-1] ? -delta : delta;
        mag_load = (abs_val > DW'(MAG_MAX)) ? MAG_MAX : abs_val[MAG_W-1:0];

        err_sum  = err_reg + ERR_W'(mag_reg);
        step     = ctl.tick && (err_sum >= ERR_W'(major));
        err_next = step ? (err_sum - ERR_W'(major)) : err_sum;
        pos_step = dir_reg ? (pos_reg + POS_BITS'(1)) : (pos_reg - POS_BITS'(1));
        pos_next = step ? pos_step : pos_reg;
        dir_next = ctl.load ? dir_load : dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            mag_reg <= '0;
            err_reg <= '0;
            dir_reg <= 1'b1;
        end
        else if (ctl.load)
        begin
            mag_reg <= mag_load;
            dir_reg <= dir_load;
            err_reg <= '0;
        end
        else if (ctl.tick)
        begin
            err_reg <= err_next;
            pos_reg <= pos_next;
        end
    end

endmodule

[src/two_axis_line_step_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-axis line step interpolator
// Bresenham DDA driving two stepper axes along a straight line.
// ----------------------------------------------------------------------------
// Each accepted command transaction passes through the input register, then
// through the DDA into the result register, to give its result transaction.
// One transaction per cycle while the result side does not hold off with
// m_tready low.
// Reset: asynchronous, active low; positions, errors and counts clear to
// zero, directions to positive, and no move is running.
// ----------------------------------------------------------------------------
module two_axis_line_step_interpolator #(
    parameter int POS_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // move_x[23:0], move_y[47:24]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // step_x[0], step_y[1], dir_x[2], dir_y[3], busy_res[4], accepted[5],
    // pos_x_now[29:6], pos_y_now[53:30], zero fill[55:54]
    output logic [55:0] m_tdata,
    output logic        m_tlast    // move_done
);
    import tlis_pkg::*;

    logic                      in_valid_reg;
    logic [1:0]                cmd_reg;
    logic signed [FIELD_W-1:0] mx_reg;
    logic signed [FIELD_W-1:0] my_reg;

    logic             running_reg;
    logic [MAG_W-1:0] major_reg;
    logic [MAG_W-1:0] iter_reg;

    logic             out_valid_reg;
    logic [55:0]      out_data_reg;
    logic             out_last_reg;

    logic             adv;
    logic             is_move;
    logic             is_tick;
    axis_ctl_t        ctl;
    logic             step_x;
    logic             step_y;
    logic             dir_x;
    logic             dir_y;
    logic signed [POS_BITS-1:0] pos_x_next;
    logic signed [POS_BITS-1:0] pos_y_next;
    logic [MAG_W-1:0] mag_x_load;
    logic [MAG_W-1:0] mag_y_load;
    logic [MAG_W-1:0] major_load;
    logic [MAG_W-1:0] iter_next;
    logic             done;
    logic             running_next;
    logic [55:0]      out_data_next;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_comb
    begin
        is_move = 1'b0;
        is_tick = 1'b0;
        case (cmd_reg)
            CMD_REL, CMD_ABS: is_move = adv && !running_reg;
            CMD_TICK:         is_tick = adv && running_reg;
            default:          ;
        endcase
        ctl.load     = is_move;
        ctl.absolute = (cmd_reg == CMD_ABS);
        ctl.tick     = is_tick;
    end

    tlis_axis #(.POS_BITS(POS_BITS)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .move     (mx_reg),
        .major    (major_reg),
        .step     (step_x),
        .dir_next (dir_x),
        .pos_next (pos_x_next),
        .mag_load (mag_x_load)
    );

    tlis_axis #(.POS_BITS(POS_BITS)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .move     (my_reg),
        .major    (major_reg),
        .step     (step_y),
        .dir_next (dir_y),
        .pos_next (pos_y_next),
        .mag_load (mag_y_load)
    );

    always_comb
    begin
        major_load   = (mag_x_load > mag_y_load) ? mag_x_load : mag_y_load;
        iter_next    = iter_reg + MAG_W'(1);
        done         = is_tick && (iter_next >= major_reg);
        running_next = running_reg;
        if (is_move)
        begin
            running_next = (major_load != '0);
        end
        else if (done)
        begin
            running_next = 1'b0;
        end
        out_data_next = {2'b00,
                         FIELD_W'(pos_y_next),
                         FIELD_W'(pos_x_next),
                         is_move,
                         running_next,
                         dir_y,
                         dir_x,
                         step_y,
                         step_x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            mx_reg  <= s_tdata[23:0];
            my_reg  <= s_tdata[47:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            major_reg   <= '0;
            iter_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            if (is_move)
            begin
                major_reg <= major_load;
                iter_reg  <= '0;
            end
            else if (is_tick)
            begin
                iter_reg <= iter_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A running move always has a nonzero major count.
    a_running_major: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (major_reg != '0))
        else $error("move running with zero major count");

    // The iteration count stays below the major count while running.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (iter_reg < major_reg))
        else $error("iteration count reached major count while running");

    // The last iteration of a move leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (!m_tdata[4] && !m_tdata[5]))
        else $error("move done reported while still busy or on a command");

    // A taken command never carries a step pulse.
    a_cmd_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> (!m_tdata[0] && !m_tdata[1]))
        else $error("step pulse on a move command result");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-axis line step interpolator testbench
// Sends relative and absolute moves followed by ticks, with noise commands
// mixed in. A scoreboard class runs its own DDA on every accepted command
// transaction and checks each result transaction field by field. The run
// goes through phases with and without random idling on either bus.
// ----------------------------------------------------------------------------
module testbench;
    import tlis_pkg::*;

    localparam int POS_BITS = 24;
    localparam logic [1:0] CMD_NOP = 2'd3;  // unused command code
    localparam int ITEM_TARGET = 1650;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic                step_x;
        logic                step_y;
        logic                dir_x;
        logic                dir_y;
        logic                busy;
        logic                done;
        logic                accepted;
        logic [FIELD_W-1:0]  pos_x;
        logic [FIELD_W-1:0]  pos_y;
    } step_result_t;

    class line_step_scoreboard;
        logic signed [POS_BITS-1:0] pos_x = '0;
        logic signed [POS_BITS-1:0] pos_y = '0;
        logic [MAG_W-1:0] mag_x = '0;
        logic [MAG_W-1:0] mag_y = '0;
        logic [MAG_W-1:0] major = '0;
        logic [MAG_W-1:0] iter_count = '0;
        logic [ERR_W-1:0] err_x = '0;
        logic [ERR_W-1:0] err_y = '0;
        logic dir_x = 1'b1;
        logic dir_y = 1'b1;
        logic running = 1'b0;
        step_result_t expected_q[$];
        int errors = 0;

        function logic [MAG_W-1:0] axis_magnitude(input longint delta, output logic dir);
            longint m;
            if (delta >= 0)
            begin
                dir = 1'b1;
                m = delta;
            end
            else
            begin
                dir = 1'b0;
                m = -delta;
            end
            if (m > longint'(MAG_MAX))
                m = longint'(MAG_MAX);
            return m[MAG_W-1:0];
        endfunction

        function void note_input(logic [1:0] cmd, logic [FIELD_W-1:0] mx,
                                 logic [FIELD_W-1:0] my);
            step_result_t r;
            longint dx;
            longint dy;
            logic signed [31:0] wide_x;
            logic signed [31:0] wide_y;
            r.step_x = 1'b0;
            r.step_y = 1'b0;
            r.done = 1'b0;
            r.accepted = 1'b0;
            if ((cmd == CMD_REL || cmd == CMD_ABS) && !running)
            begin
                dx = longint'(signed'(mx));
                dy = longint'(signed'(my));
                if (cmd == CMD_ABS)
                begin
                    dx = dx - longint'(pos_x);
                    dy = dy - longint'(pos_y);
                end
                r.accepted = 1'b1;
                mag_x = axis_magnitude(dx, dir_x);
                mag_y = axis_magnitude(dy, dir_y);
                major = (mag_x > mag_y) ? mag_x : mag_y;
                iter_count = '0;
                err_x = '0;
                err_y = '0;
                running = (major != '0);
            end
            else if (cmd == CMD_TICK && running)
            begin
                err_x = err_x + mag_x;
                err_y = err_y + mag_y;
                if (err_x >= major)
                begin
                    r.step_x = 1'b1;
                    err_x = err_x - major;
                    pos_x = dir_x ? pos_x + 1'b1 : pos_x - 1'b1;
                end
                if (err_y >= major)
                begin
                    r.step_y = 1'b1;
                    err_y = err_y - major;
                    pos_y = dir_y ? pos_y + 1'b1 : pos_y - 1'b1;
                end
                iter_count = iter_count + 1'b1;
                if (iter_count >= major)
                begin
                    running = 1'b0;
                    r.done = 1'b1;
                end
            end
            wide_x = 32'(pos_x);
            wide_y = 32'(pos_y);
            r.dir_x = dir_x;
            r.dir_y = dir_y;
            r.busy = running;
            r.pos_x = wide_x[FIELD_W-1:0];
            r.pos_y = wide_y[FIELD_W-1:0];
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_LIMIT)
                $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(logic [55:0] data, logic last);
            step_result_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0h arrived with none pending", data));
                return;
            end
            e = expected_q.pop_front();
            check_field("step_x", 32'(data[0]), 32'(e.step_x));
            check_field("step_y", 32'(data[1]), 32'(e.step_y));
            check_field("dir_x", 32'(data[2]), 32'(e.dir_x));
            check_field("dir_y", 32'(data[3]), 32'(e.dir_y));
            check_field("busy", 32'(data[4]), 32'(e.busy));
            check_field("accepted", 32'(data[5]), 32'(e.accepted));
            check_field("pos_x_now", 32'(data[29:6]), 32'(e.pos_x));
            check_field("pos_y_now", 32'(data[53:30]), 32'(e.pos_y));
            check_field("move_done", 32'(last), 32'(e.done));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sent_items = 0;

    line_step_scoreboard sb = new;

    two_axis_line_step_interpolator #(
        .POS_BITS(POS_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: check every transaction, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(logic [1:0] cmd, logic [FIELD_W-1:0] mx,
                             logic [FIELD_W-1:0] my);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {my, mx};
        s_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
        sb.note_input(cmd, mx, my);
    endtask

    // Holds the bus idle until the scoreboard has seen every result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [FIELD_W-1:0] random_delta(int span);
        int m;
        m = $urandom_range(span);
        return $urandom_range(1) ? FIELD_W'(-m) : FIELD_W'(m);
    endfunction

    task automatic random_move();
        int span;
        logic [FIELD_W-1:0] dx;
        logic [FIELD_W-1:0] dy;
        span = ($urandom_range(39) == 0) ? 400 : 12;
        dx = random_delta(span);
        dy = ($urandom_range(9) == 0) ? '0 : random_delta(span);
        if ($urandom_range(9) < 6)
            send_item(CMD_REL, dx, dy);
        else
            send_item(CMD_ABS, FIELD_W'(sb.pos_x) + dx, FIELD_W'(sb.pos_y) + dy);
    endtask

    // Runs the current move to its end, with rejected moves and unused
    // command codes mixed in among the ticks.
    task automatic finish_move();
        int k;
        while (sb.running)
        begin
            k = $urandom_range(99);
            if (k < 84)
                send_item(CMD_TICK, FIELD_W'($urandom), FIELD_W'($urandom));
            else if (k < 92)
                send_item($urandom_range(1) ? CMD_ABS : CMD_REL,
                          FIELD_W'($urandom), FIELD_W'($urandom));
            else
                send_item(CMD_NOP, FIELD_W'($urandom), FIELD_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: idle tick, unused code, zero-length move, a
        // negative single step, moves refused while busy, absolute moves.
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_NOP, 24'hFFFFFF, 24'hFFFFFF);
        send_item(CMD_REL, '0, '0);
        send_item(CMD_REL, 24'hFFFFFF, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_REL, 24'd3, 24'hFFFFFB);
        send_item(CMD_REL, 24'h7FFFFF, 24'h800000);
        send_item(CMD_TICK, 24'hFFFFFF, 24'hFFFFFF);
        send_item(CMD_ABS, 24'h800000, 24'h7FFFFF);
        send_item(CMD_NOP, 24'h7FFFFF, 24'h800000);
        finish_move();
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_ABS, 24'd2, 24'hFFFFFD);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_ABS, 24'd2, 24'hFFFFFD);
        send_item(CMD_ABS, 24'hFFFFFC, 24'hFFFFFC);
        finish_move();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            if (phase > 0)
                drain_results();
            while (sent_items < (phase + 1) * ITEM_TARGET / 4)
            begin
                if ($urandom_range(9) == 0)
                    send_item($urandom_range(1) ? CMD_TICK : CMD_NOP,
                              FIELD_W'($urandom), FIELD_W'($urandom));
                random_move();
                finish_move();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results pending", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
